// ===== src/sst_pkg.sv =====
// sst_pkg: command, host type, family and status codes of the server slot table
// plus the request, lookup key and table write types used by its modules
// no dependencies
`timescale 1ns / 1ps

package sst_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;

  localparam logic [1:0] HOST_IPV4 = 2'd0;
  localparam logic [1:0] HOST_IPV6 = 2'd1;

  localparam logic [1:0] FAM_EMPTY = 2'd0;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [7:0] FAIL_LIMIT = 8'd10;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  host_type;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port_number;
    logic [2:0]  slot_select;
    logic [7:0]  failure_value;
  } item_t;

  // endpoint as stored in a slot, address already normalized
  typedef struct packed {
    logic [1:0]  fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
  } key_t;

  // table write controls, at most one set per cycle
  typedef struct packed {
    logic insert;
    logic remove;
    logic set_fail;
  } tbl_op_t;

endpackage

// ===== src/sst_if.sv =====
// sst_req_if and sst_rsp_if: valid/ready channels of the server slot table
// no dependencies
`timescale 1ns / 1ps

interface sst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  host_type;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] port_number;
  logic [2:0]  slot_select;
  logic [7:0]  failure_value;

  modport source (
    output valid, command, host_type, addr_high, addr_low, port_number,
           slot_select, failure_value,
    input  ready
  );
  modport sink (
    input  valid, command, host_type, addr_high, addr_low, port_number,
           slot_select, failure_value,
    output ready
  );
endinterface

interface sst_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot_used;

  modport source (output valid, status, slot_used, input ready);
  modport sink (input valid, status, slot_used, output ready);
endinterface

// ===== src/sst_table.sv =====
// sst_table: slot storage with one endpoint comparator per slot
// depends on sst_pkg
`timescale 1ns / 1ps

module sst_table #(
  parameter int TABLE_SLOTS = 8,
  parameter int IDX_W = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sst_pkg::tbl_op_t       op,
  input  logic [IDX_W-1:0]       idx,
  input  sst_pkg::key_t          key,
  input  logic [7:0]             fail_value,
  output logic [TABLE_SLOTS-1:0] match,
  output logic [TABLE_SLOTS-1:0] empty,
  output logic [TABLE_SLOTS-1:0] worn
);

  logic [1:0]  family   [TABLE_SLOTS];
  logic [63:0] addr_hi  [TABLE_SLOTS];
  logic [63:0] addr_lo  [TABLE_SLOTS];
  logic [15:0] port     [TABLE_SLOTS];
  logic [7:0]  failures [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        family[i]   <= sst_pkg::FAM_EMPTY;
        failures[i] <= 8'd0;
      end
    end else begin
      if (op.insert) begin
        family[idx]   <= key.fam;
        failures[idx] <= 8'd0;
      end else if (op.remove) begin
        family[idx] <= sst_pkg::FAM_EMPTY;
      end else if (op.set_fail) begin
        failures[idx] <= fail_value;
      end
    end
  end

  // address and port need no reset, an empty family hides them
  always_ff @(posedge clk) begin
    if (op.insert) begin
      addr_hi[idx] <= key.hi;
      addr_lo[idx] <= key.lo;
      port[idx]    <= key.port;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      empty[i] = (family[i] == sst_pkg::FAM_EMPTY);
      match[i] = !empty[i] && (family[i] == key.fam) && (port[i] == key.port) &&
                 (addr_hi[i] == key.hi) && (addr_lo[i] == key.lo);
      worn[i]  = (failures[i] > sst_pkg::FAIL_LIMIT);
    end
  end

endmodule

// ===== src/sst_decide.sv =====
// sst_decide: priority encoders and command decode, gives status and the write
// depends on sst_pkg
`timescale 1ns / 1ps

module sst_decide #(
  parameter int TABLE_SLOTS = 8,
  parameter int IDX_W = 3
) (
  input  logic [1:0]             command,
  input  logic [1:0]             host_type,
  input  logic [2:0]             slot_select,
  input  logic [TABLE_SLOTS-1:0] match,
  input  logic [TABLE_SLOTS-1:0] empty,
  input  logic [TABLE_SLOTS-1:0] worn,
  output sst_pkg::tbl_op_t       op,
  output logic [IDX_W-1:0]       idx,
  output logic [2:0]             status,
  output logic [2:0]             slot_used
);

  logic             type_ok;
  logic             hit_any;
  logic             empty_any;
  logic             worn_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] empty_idx;
  logic [IDX_W-1:0] worn_idx;

  assign type_ok = (host_type == sst_pkg::HOST_IPV4) || (host_type == sst_pkg::HOST_IPV6);

  // lowest set bit wins
  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    worn_any  = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    worn_idx  = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (empty[i]) begin
        empty_any = 1'b1;
        empty_idx = IDX_W'(i);
      end
      if (worn[i]) begin
        worn_any = 1'b1;
        worn_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    op     = '0;
    idx    = '0;
    status = sst_pkg::ST_OK;
    case (command)
      sst_pkg::CMD_ADD: begin
        if (!type_ok) begin
          status = sst_pkg::ST_INVALID;
        end else if (hit_any) begin
          status = sst_pkg::ST_EXISTS;
        end else if (empty_any) begin
          op.insert = 1'b1;
          idx       = empty_idx;
        end else if (worn_any) begin
          op.insert = 1'b1;
          idx       = worn_idx;
        end else begin
          status = sst_pkg::ST_NOSPACE;
        end
      end
      sst_pkg::CMD_REMOVE: begin
        if (type_ok && hit_any) begin
          op.remove = 1'b1;
          idx       = hit_idx;
        end else begin
          status = sst_pkg::ST_NOTFOUND;
        end
      end
      sst_pkg::CMD_SET: begin
        if (int'(slot_select) < TABLE_SLOTS) begin
          op.set_fail = 1'b1;
          idx         = IDX_W'(slot_select);
        end else begin
          status = sst_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status = sst_pkg::ST_INVALID;
      end
    endcase
  end

  // low bits of the slot index, zero on any failure
  assign slot_used = (status == sst_pkg::ST_OK) ? 3'(idx) : 3'd0;

endmodule

// ===== src/server_slot_table.sv =====
// server_slot_table: top level, input register, slot table and result register
// depends on sst_pkg, sst_if, sst_table, sst_decide
//
// usage:
//   req carries one command per request: add an endpoint (family, address,
//   port), remove an endpoint, or write the failure count of one slot.
//   rsp returns one result per request: a status code and the slot touched.
//   a request is taken when req.valid and req.ready are both high, and a
//   result is taken when rsp.valid and rsp.ready are both high.
//   pipeline: a request accepted into the input register is decoded against
//   the table there, and its result shows on rsp once it moves on into the
//   result register.
//   throughput: one request per cycle unless rsp stalls; the table lookup,
//   the priority encoders and the table write all sit between the input
//   and result registers, so the next request already sees the updated table.
//   reset: rst clears the valid bits of both pipeline registers and empties
//   every slot; the block takes requests as soon as rst is low.
//   stall: while rsp.ready is low a waiting result stays in the result register,
//   the input register still fills once and then req.ready drops until rsp moves.
`timescale 1ns / 1ps

module server_slot_table #(
  parameter int TABLE_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  sst_req_if.sink    req,
  sst_rsp_if.source  rsp
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic                   in_valid;
  sst_pkg::item_t         in_item;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [2:0]             out_slot;
  logic                   advance;
  sst_pkg::key_t          key;
  sst_pkg::tbl_op_t       op;
  sst_pkg::tbl_op_t       op_gated;
  logic [IDX_W-1:0]       idx;
  logic [2:0]             status;
  logic [2:0]             slot_used;
  logic [TABLE_SLOTS-1:0] match;
  logic [TABLE_SLOTS-1:0] empty;
  logic [TABLE_SLOTS-1:0] worn;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.command       <= req.command;
      in_item.host_type     <= req.host_type;
      in_item.addr_high     <= req.addr_high;
      in_item.addr_low      <= req.addr_low;
      in_item.port_number   <= req.port_number;
      in_item.slot_select   <= req.slot_select;
      in_item.failure_value <= req.failure_value;
    end
  end

  // ipv4 keeps only the low 32 address bits
  always_comb begin
    key.fam  = in_item.host_type + 2'd1;
    key.port = in_item.port_number;
    if (in_item.host_type == sst_pkg::HOST_IPV4) begin
      key.hi = 64'd0;
      key.lo = {32'd0, in_item.addr_low[31:0]};
    end else begin
      key.hi = in_item.addr_high;
      key.lo = in_item.addr_low;
    end
  end

  sst_table #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .IDX_W(IDX_W)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .op(op_gated),
    .idx(idx),
    .key(key),
    .fail_value(in_item.failure_value),
    .match(match),
    .empty(empty),
    .worn(worn)
  );

  sst_decide #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .IDX_W(IDX_W)
  ) u_decide (
    .command(in_item.command),
    .host_type(in_item.host_type),
    .slot_select(in_item.slot_select),
    .match(match),
    .empty(empty),
    .worn(worn),
    .op(op),
    .idx(idx),
    .status(status),
    .slot_used(slot_used)
  );

  // table changes only when the request moves on to the result register
  assign op_gated = advance ? op : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status;
      out_slot   <= slot_used;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.slot_used = out_slot;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for server_slot_table, directed rows then random requests
// keeps a shadow slot table to predict status and slot where a row gives none, stalls both channels at random
// depends on sst_pkg, sst_if and server_slot_table
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS = 8;
  localparam int RANDOM_REQS = 1925;
  localparam int POOL_SIZE = 12;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [1:0] HOST_BAD2 = 2'd2;
  localparam logic [1:0] HOST_BAD3 = 2'd3;
  localparam logic [1:0] FAM_V4    = 2'd1;
  localparam logic [1:0] FAM_V6    = 2'd2;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_used;
  } result_t;

  typedef struct {
    sst_pkg::item_t it;
    bit             typed;
    result_t        res;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  host_type;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
  } endpoint_t;

  logic clk;
  logic rst;
  sst_req_if req_ch ();
  sst_rsp_if rsp_ch ();

  server_slot_table #(.TABLE_SLOTS(SLOTS)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow copy of the slot table
  logic [1:0]  slot_fam   [SLOTS];
  logic [63:0] slot_hi    [SLOTS];
  logic [63:0] slot_lo    [SLOTS];
  logic [15:0] slot_prt   [SLOTS];
  logic [7:0]  slot_fails [SLOTS];

  result_t   pending_results[$];
  dir_row_t  directed[$];
  endpoint_t pool [POOL_SIZE];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int idle_cycles = 0;
  int status_seen [5] = '{default: 0};
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t apply_command(sst_pkg::item_t it);
    logic [1:0]  fam;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          ok_type;
    int          hit;
    int          free;
    result_t     r;
    ok_type = (it.host_type == sst_pkg::HOST_IPV4) || (it.host_type == sst_pkg::HOST_IPV6);
    fam = (it.host_type == sst_pkg::HOST_IPV4) ? FAM_V4 : FAM_V6;
    hi = (it.host_type == sst_pkg::HOST_IPV4) ? 64'd0 : it.addr_high;
    lo = (it.host_type == sst_pkg::HOST_IPV4) ? {32'd0, it.addr_low[31:0]} : it.addr_low;
    hit = -1;
    free = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_fam[i] != sst_pkg::FAM_EMPTY && slot_fam[i] == fam && slot_hi[i] == hi &&
          slot_lo[i] == lo && slot_prt[i] == it.port_number)
        hit = i;
    end
    // lowest empty slot wins, else the lowest worn-out one
    for (int i = SLOTS - 1; i >= 0; i--)
      if (slot_fails[i] > sst_pkg::FAIL_LIMIT) free = i;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (slot_fam[i] == sst_pkg::FAM_EMPTY) free = i;
    r = '{status: sst_pkg::ST_OK, slot_used: 3'd0};
    case (it.command)
      sst_pkg::CMD_ADD: begin
        if (!ok_type) begin
          r.status = sst_pkg::ST_INVALID;
        end else if (hit >= 0) begin
          r.status = sst_pkg::ST_EXISTS;
        end else if (free < 0) begin
          r.status = sst_pkg::ST_NOSPACE;
        end else begin
          slot_fam[free] = fam;
          slot_hi[free] = hi;
          slot_lo[free] = lo;
          slot_prt[free] = it.port_number;
          slot_fails[free] = 8'd0;
          r.slot_used = free[2:0];
        end
      end
      sst_pkg::CMD_REMOVE: begin
        if (!ok_type || hit < 0) begin
          r.status = sst_pkg::ST_NOTFOUND;
        end else begin
          // only the family goes, the rest of the slot stays
          slot_fam[hit] = sst_pkg::FAM_EMPTY;
          r.slot_used = hit[2:0];
        end
      end
      sst_pkg::CMD_SET: begin
        if (int'(it.slot_select) >= SLOTS) begin
          r.status = sst_pkg::ST_NOTFOUND;
        end else begin
          slot_fails[it.slot_select] = it.failure_value;
          r.slot_used = it.slot_select;
        end
      end
      default: r.status = sst_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [1:0] ht, logic [63:0] hi,
                                  logic [63:0] lo, logic [15:0] prt, logic [2:0] sel,
                                  logic [7:0] fval, bit typed = 1'b0,
                                  logic [2:0] st = sst_pkg::ST_OK, logic [2:0] sl = 3'd0);
    dir_row_t row;
    row.it = '{command: cmd, host_type: ht, addr_high: hi, addr_low: lo,
               port_number: prt, slot_select: sel, failure_value: fval};
    row.typed = typed;
    row.res = '{status: st, slot_used: sl};
    directed.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic sst_pkg::item_t noise_item();
    sst_pkg::item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.host_type = 2'($urandom_range(0, 3));
    it.addr_high = {$urandom, $urandom};
    it.addr_low = {$urandom, $urandom};
    it.port_number = 16'($urandom);
    it.slot_select = 3'($urandom);
    it.failure_value = 8'($urandom);
    return it;
  endfunction

  // new endpoint, often a near copy of another so that single fields decide the match
  function automatic void refresh_endpoint(int k);
    endpoint_t ep;
    ep = pool[$urandom_range(0, POOL_SIZE - 1)];
    case ($urandom_range(0, 4))
      0: ep.host_type = {1'b0, ~ep.host_type[0]};
      1: ep.port = ep.port ^ (16'd1 << $urandom_range(0, 15));
      2: ep.hi = ep.hi ^ (64'd1 << $urandom_range(0, 63));
      3: ep.lo = ep.lo ^ (64'd1 << $urandom_range(0, 63));
      default: begin
        ep.host_type = 2'($urandom_range(0, 1));
        ep.hi = {$urandom, $urandom};
        ep.lo = {$urandom, $urandom};
        ep.port = 16'($urandom);
      end
    endcase
    pool[k] = ep;
  endfunction

  function automatic sst_pkg::item_t random_request();
    sst_pkg::item_t it;
    endpoint_t      ep;
    int             pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      ep = pool[$urandom_range(0, POOL_SIZE - 1)];
      it.command = (pick < 45) ? sst_pkg::CMD_ADD : sst_pkg::CMD_REMOVE;
      it.host_type = ep.host_type;
      it.port_number = ep.port;
      if (ep.host_type == sst_pkg::HOST_IPV6) begin
        it.addr_high = ep.hi;
        it.addr_low = ep.lo;
      end else begin
        // ipv4: upper address bits are don't care, sometimes junk
        it.addr_low[31:0] = ep.lo[31:0];
        if ($urandom_range(0, 1) == 0) begin
          it.addr_high = '0;
          it.addr_low[63:32] = '0;
        end
      end
    end else if (pick < 85) begin
      it.command = sst_pkg::CMD_SET;
      if ($urandom_range(0, 1) == 0) it.failure_value = 8'($urandom_range(9, 12));
    end
    return it;
  endfunction

  task automatic send_request(sst_pkg::item_t it, bit typed, result_t typed_res);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      {req_ch.command, req_ch.host_type, req_ch.addr_high, req_ch.addr_low,
       req_ch.port_number, req_ch.slot_select, req_ch.failure_value} = noise_item();
    end
    @(negedge clk);
    {req_ch.command, req_ch.host_type, req_ch.addr_high, req_ch.addr_low,
     req_ch.port_number, req_ch.slot_select, req_ch.failure_value} = it;
    req_ch.valid = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_command(it);
    pending_results.push_back(typed ? typed_res : predicted);
    sent++;
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        hold = pick_gap();
        rsp_ch.ready = (hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: no progress for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end else if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $error("unrequested result: status %0d slot_used %0d", rsp_ch.status,
               rsp_ch.slot_used);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (want.status <= sst_pkg::ST_NOTFOUND) status_seen[want.status]++;
        if (rsp_ch.status !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
        end
        if (rsp_ch.slot_used !== want.slot_used) begin
          errors++;
          $error("slot_used: expected %0d, got %0d", want.slot_used, rsp_ch.slot_used);
        end
      end
    end
  end

  initial begin
    result_t none;
    none = '{status: sst_pkg::ST_OK, slot_used: 3'd0};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = sst_pkg::CMD_ADD;
    req_ch.host_type = sst_pkg::HOST_IPV4;
    req_ch.addr_high = '0;
    req_ch.addr_low = '0;
    req_ch.port_number = '0;
    req_ch.slot_select = '0;
    req_ch.failure_value = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_fam[i] = sst_pkg::FAM_EMPTY;
      slot_hi[i] = '0;
      slot_lo[i] = '0;
      slot_prt[i] = '0;
      slot_fails[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // set on an empty slot still writes
    add_row(sst_pkg::CMD_SET, sst_pkg::HOST_IPV4, '0, '0, '0, 3'd0, 8'hFF, 1'b1,
            sst_pkg::ST_OK, 3'd0);
    add_row(sst_pkg::CMD_REMOVE, sst_pkg::HOST_IPV4, '0, 64'd1, 16'd80, '0, '0, 1'b1,
            sst_pkg::ST_NOTFOUND);
    add_row(sst_pkg::CMD_ADD, HOST_BAD2, '0, 64'd5, 16'd5, '0, '0, 1'b1, sst_pkg::ST_INVALID);
    add_row(sst_pkg::CMD_ADD, HOST_BAD3, '1, '1, '1, '1, '1, 1'b1, sst_pkg::ST_INVALID);
    add_row(CMD_NONE, sst_pkg::HOST_IPV4, '0, '0, '0, '0, '0, 1'b1, sst_pkg::ST_INVALID);
    // ipv4 ignores addr_high and addr_low above bit 31
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '1, '1, '1, '0, '0, 1'b1,
            sst_pkg::ST_OK, 3'd0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '0, 64'hFFFF_FFFF, '1, '0, '0, 1'b1,
            sst_pkg::ST_EXISTS);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, '0, 64'hFFFF_FFFF, '1, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, '1, '1, '1, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, '0, '0, '0, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '0, '0, '0, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, 64'h8000_0000_0000_0000, 64'd1, 16'd1,
            '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '0, 64'h1_0000_0001, 16'd2, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '0, 64'hC0A8_0001, 16'd443, '0, '0);
    // full table, nothing worn out yet
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '0, 64'hC0A8_0002, 16'd443, '0, '0, 1'b1,
            sst_pkg::ST_NOSPACE);
    add_row(sst_pkg::CMD_SET, sst_pkg::HOST_IPV4, '0, '0, '0, 3'd3, 8'd11);
    add_row(sst_pkg::CMD_SET, sst_pkg::HOST_IPV4, '0, '0, '0, 3'd5, 8'd255);
    add_row(sst_pkg::CMD_SET, sst_pkg::HOST_IPV4, '0, '0, '0, 3'd6, 8'd10);
    // worn-out slots reused lowest first, a count of exactly ten does not qualify
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV4, '0, 64'hC0A8_0002, 16'd443, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, 64'd1, 64'd2, 16'd3, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, 64'd1, 64'd2, 16'd4, '0, '0);
    add_row(sst_pkg::CMD_REMOVE, HOST_BAD2, '1, '1, '1, '0, '0, 1'b1, sst_pkg::ST_NOTFOUND);
    add_row(sst_pkg::CMD_REMOVE, sst_pkg::HOST_IPV4, '0, '1, '1, '0, '0);
    add_row(sst_pkg::CMD_REMOVE, sst_pkg::HOST_IPV4, '0, '1, '1, '0, '0);
    add_row(sst_pkg::CMD_ADD, sst_pkg::HOST_IPV6, 64'd1, 64'd2, 16'd4, '0, '0);

    foreach (directed[i]) send_request(directed[i].it, directed[i].typed, directed[i].res);

    // small endpoint pool so adds collide, removes hit and the table fills up
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool[k].host_type = 2'($urandom_range(0, 1));
      pool[k].hi = {$urandom, $urandom};
      pool[k].lo = {$urandom, $urandom};
      pool[k].port = 16'($urandom);
    end
    for (int k = POOL_SIZE / 2; k < POOL_SIZE; k++) refresh_endpoint(k);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 300 == 150) calm = 1'b1;
      if (n % 300 == 230) calm = 1'b0;
      if (n % 500 == 499) begin
        // hold off until every request is answered
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) refresh_endpoint($urandom_range(0, POOL_SIZE - 1));
      send_request(random_request(), 1'b0, none);
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb_top: %0d requests sent, %0d results compared, %0d mismatches",
             sent, checked, errors);
    $display("tb_top: ok %0d, invalid %0d, exists %0d, no space %0d, not found %0d",
             status_seen[sst_pkg::ST_OK], status_seen[sst_pkg::ST_INVALID],
             status_seen[sst_pkg::ST_EXISTS], status_seen[sst_pkg::ST_NOSPACE],
             status_seen[sst_pkg::ST_NOTFOUND]);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
